[src/vn2d_pkg.sv]
package vn2d_pkg;

    localparam int IN_WIDTH_DEF = 16;
    localparam int OUT_FRAC_DEF = 14;

endpackage

[src/vn2d_front.sv]
module vn2d_front #(
    parameter int IN_WIDTH = vn2d_pkg::IN_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [IN_WIDTH-1:0]   s_vec_x,
    input  logic [IN_WIDTH-1:0]   s_vec_y,
    output logic                  o_valid,
    input  logic                  o_ready,
    output logic [2*IN_WIDTH-1:0] o_sum,
    output logic [IN_WIDTH-1:0]   o_mag_x,
    output logic [IN_WIDTH-1:0]   o_mag_y,
    output logic                  o_neg_x,
    output logic                  o_neg_y
);

    localparam int SW = 2 * IN_WIDTH;

    logic                valid_reg;
    logic [SW-1:0]       sum_reg;
    logic [IN_WIDTH-1:0] mag_x_reg, mag_y_reg;
    logic                neg_x_reg, neg_y_reg;

    logic                neg_x, neg_y;
    logic [IN_WIDTH-1:0] mag_x, mag_y;
    logic [SW-1:0]       sq_x, sq_y;

    // magnitude of the most negative value wraps to 2^(W-1), which is exact unsigned
    assign neg_x = s_vec_x[IN_WIDTH-1];
    assign neg_y = s_vec_y[IN_WIDTH-1];
    assign mag_x = neg_x ? (~s_vec_x + 1'b1) : s_vec_x;
    assign mag_y = neg_y ? (~s_vec_y + 1'b1) : s_vec_y;
    assign sq_x  = SW'(mag_x) * SW'(mag_x);
    assign sq_y  = SW'(mag_y) * SW'(mag_y);

    assign s_ready = !valid_reg || o_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            sum_reg   <= sq_x + sq_y;
            mag_x_reg <= mag_x;
            mag_y_reg <= mag_y;
            neg_x_reg <= neg_x;
            neg_y_reg <= neg_y;
        end
    end

    assign o_valid = valid_reg;
    assign o_sum   = sum_reg;
    assign o_mag_x = mag_x_reg;
    assign o_mag_y = mag_y_reg;
    assign o_neg_x = neg_x_reg;
    assign o_neg_y = neg_y_reg;

endmodule

[src/vn2d_fifo.sv]
module vn2d_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [0:1];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             push, pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[src/vn2d_back.sv]
module vn2d_back #(
    parameter int IN_WIDTH = vn2d_pkg::IN_WIDTH_DEF,
    parameter int OUT_FRAC = vn2d_pkg::OUT_FRAC_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  i_valid,
    output logic                  i_ready,
    input  logic [2*IN_WIDTH-1:0] i_sum,
    input  logic [IN_WIDTH-1:0]   i_mag_x,
    input  logic [IN_WIDTH-1:0]   i_mag_y,
    input  logic                  i_neg_x,
    input  logic                  i_neg_y,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [OUT_FRAC+1:0]   m_norm_x,
    output logic [OUT_FRAC+1:0]   m_norm_y,
    output logic [IN_WIDTH-1:0]   m_length,
    output logic                  m_was_zero
);

    localparam int LW = IN_WIDTH;      // root width
    localparam int SW = 2 * IN_WIDTH;  // radicand width
    localparam int RW = LW + 3;        // sqrt partial remainder
    localparam int QW = OUT_FRAC + 1;  // quotient bits, q <= 2^OUT_FRAC
    localparam int NW = OUT_FRAC + 2;

    logic en;

    // sqrt pipeline, one result bit per stage
    logic          sq_vld  [0:LW];
    logic [SW-1:0] sq_rad  [0:LW];
    logic [RW-1:0] sq_rem  [0:LW];
    logic [LW-1:0] sq_root [0:LW];
    logic [LW-1:0] sq_mx   [0:LW];
    logic [LW-1:0] sq_my   [0:LW];
    logic          sq_nx   [0:LW];
    logic          sq_ny   [0:LW];

    assign sq_vld[0]  = i_valid;
    assign sq_rad[0]  = i_sum;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_mx[0]   = i_mag_x;
    assign sq_my[0]   = i_mag_y;
    assign sq_nx[0]   = i_neg_x;
    assign sq_ny[0]   = i_neg_y;

    for (genvar k = 0; k < LW; k++) begin : g_sqrt
        logic [RW-1:0] rem_sh, trial;
        logic          ge;

        assign rem_sh = {sq_rem[k][RW-3:0], sq_rad[k][SW-1:SW-2]};
        assign trial  = RW'({sq_root[k], 2'b01});
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_vld[k+1] <= 1'b0;
            end else if (en) begin
                sq_vld[k+1] <= sq_vld[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                sq_rad[k+1]  <= sq_rad[k] << 2;
                sq_rem[k+1]  <= ge ? (rem_sh - trial) : rem_sh;
                sq_root[k+1] <= {sq_root[k][LW-2:0], ge};
                sq_mx[k+1]   <= sq_mx[k];
                sq_my[k+1]   <= sq_my[k];
                sq_nx[k+1]   <= sq_nx[k];
                sq_ny[k+1]   <= sq_ny[k];
            end
        end
    end

    // restoring division of (mag << OUT_FRAC) by the length, x and y side by side.
    // dividend high part is mag >> 1; the low bits bring in mag[0] and then zeros.
    logic          dv_vld [0:QW];
    logic [LW:0]   dv_rx  [0:QW];
    logic [LW:0]   dv_ry  [0:QW];
    logic [QW-1:0] dv_qx  [0:QW];
    logic [QW-1:0] dv_qy  [0:QW];
    logic          dv_bx  [0:QW];
    logic          dv_by  [0:QW];
    logic [LW-1:0] dv_len [0:QW];
    logic          dv_nx  [0:QW];
    logic          dv_ny  [0:QW];

    assign dv_vld[0] = sq_vld[LW];
    assign dv_rx[0]  = (LW+1)'(sq_mx[LW] >> 1);
    assign dv_ry[0]  = (LW+1)'(sq_my[LW] >> 1);
    assign dv_qx[0]  = '0;
    assign dv_qy[0]  = '0;
    assign dv_bx[0]  = sq_mx[LW][0];
    assign dv_by[0]  = sq_my[LW][0];
    assign dv_len[0] = sq_root[LW];
    assign dv_nx[0]  = sq_nx[LW];
    assign dv_ny[0]  = sq_ny[LW];

    for (genvar d = 0; d < QW; d++) begin : g_div
        logic [LW:0] shx, shy, dvs;
        logic        gex, gey;

        assign shx = {dv_rx[d][LW-1:0], dv_bx[d]};
        assign shy = {dv_ry[d][LW-1:0], dv_by[d]};
        assign dvs = {1'b0, dv_len[d]};
        assign gex = (shx >= dvs);
        assign gey = (shy >= dvs);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_vld[d+1] <= 1'b0;
            end else if (en) begin
                dv_vld[d+1] <= dv_vld[d];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dv_rx[d+1]  <= gex ? (shx - dvs) : shx;
                dv_ry[d+1]  <= gey ? (shy - dvs) : shy;
                dv_qx[d+1]  <= {dv_qx[d][QW-2:0], gex};
                dv_qy[d+1]  <= {dv_qy[d][QW-2:0], gey};
                dv_bx[d+1]  <= 1'b0;
                dv_by[d+1]  <= 1'b0;
                dv_len[d+1] <= dv_len[d];
                dv_nx[d+1]  <= dv_nx[d];
                dv_ny[d+1]  <= dv_ny[d];
            end
        end
    end

    // whole pipeline moves together; a stalled output holds every stage
    assign en      = !dv_vld[QW] || m_ready;
    assign i_ready = en;

    logic          zero;
    logic [NW-1:0] qx_ext, qy_ext;

    assign zero   = (dv_len[QW] == '0);
    assign qx_ext = NW'(dv_qx[QW]);
    assign qy_ext = NW'(dv_qy[QW]);

    assign m_valid    = dv_vld[QW];
    assign m_length   = dv_len[QW];
    assign m_was_zero = zero;
    assign m_norm_x   = zero ? '0 : (dv_nx[QW] ? (~qx_ext + 1'b1) : qx_ext);
    assign m_norm_y   = zero ? '0 : (dv_ny[QW] ? (~qy_ext + 1'b1) : qy_ext);

endmodule

[src/vector_normalize_2d_core.sv]
// Path from input transaction to result: the squaring register, the queue, IN_WIDTH sqrt
// stages and OUT_FRAC+1 divide stages; the sqrt and divide units are fully pipelined.
// Throughput: one vector per cycle while m_ready does not stall the output.
// Reset: synchronous, active-low aresetn clears all valid flags and the queue; data
// registers are not reset.
module vector_normalize_2d_core #(
    parameter int IN_WIDTH = vn2d_pkg::IN_WIDTH_DEF,
    parameter int OUT_FRAC = vn2d_pkg::OUT_FRAC_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [IN_WIDTH-1:0] s_vec_x,
    input  logic [IN_WIDTH-1:0] s_vec_y,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [OUT_FRAC+1:0] m_norm_x,
    output logic [OUT_FRAC+1:0] m_norm_y,
    output logic [IN_WIDTH-1:0] m_length,
    output logic                m_was_zero
);

    localparam int SW = 2 * IN_WIDTH;
    localparam int QD = SW + 2 * IN_WIDTH + 2;

    logic                f_valid, f_ready;
    logic [SW-1:0]       f_sum;
    logic [IN_WIDTH-1:0] f_mag_x, f_mag_y;
    logic                f_neg_x, f_neg_y;

    logic                b_valid, b_ready;
    logic [QD-1:0]       b_data;

    vn2d_front #(.IN_WIDTH(IN_WIDTH)) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_vec_x (s_vec_x),
        .s_vec_y (s_vec_y),
        .o_valid (f_valid),
        .o_ready (f_ready),
        .o_sum   (f_sum),
        .o_mag_x (f_mag_x),
        .o_mag_y (f_mag_y),
        .o_neg_x (f_neg_x),
        .o_neg_y (f_neg_y)
    );

    vn2d_fifo #(.WIDTH(QD)) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  ({f_sum, f_mag_x, f_mag_y, f_neg_x, f_neg_y}),
        .rd_valid (b_valid),
        .rd_ready (b_ready),
        .rd_data  (b_data)
    );

    vn2d_back #(.IN_WIDTH(IN_WIDTH), .OUT_FRAC(OUT_FRAC)) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .i_valid    (b_valid),
        .i_ready    (b_ready),
        .i_sum      (b_data[QD-1 -: SW]),
        .i_mag_x    (b_data[2*IN_WIDTH+1 -: IN_WIDTH]),
        .i_mag_y    (b_data[IN_WIDTH+1 -: IN_WIDTH]),
        .i_neg_x    (b_data[1]),
        .i_neg_y    (b_data[0]),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_norm_x   (m_norm_x),
        .m_norm_y   (m_norm_y),
        .m_length   (m_length),
        .m_was_zero (m_was_zero)
    );

endmodule
